/* hdl/bpa_pkg.sv */
// Shared types, constants and helper functions of the buddy page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int FRAMES     = 1024;
   localparam int MAX_ORDERS = 11;
   localparam int FRM_W      = 10;
   localparam int ORD_W      = 4;
   localparam int CNT_W      = 11;
   localparam int ST_DEPTH   = 2048;
   localparam int ST_AW      = 11;

   typedef enum logic [1:0] {
      ACT_RESERVE = 2'd0,
      ACT_BUILD   = 2'd1,
      ACT_ALLOC   = 2'd2,
      ACT_FREE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_MEM    = 2'd1,
      ST_DBL_FREE  = 2'd2,
      ST_LIST_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MK_USED  = 2'd0,
      MK_FREE  = 2'd1,
      MK_BUILD = 2'd2
   } mark_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RSV_RD, S_RSV_WR, S_BLD_RD, S_BLD_CHK, S_BLD_DEC,
      S_MK_RD, S_MK_WR, S_AL_SRCH, S_AL_POP, S_AL_SPLIT, S_FR_RD, S_FR_CHK,
      S_FR_MERGE, S_FR_BUD, S_RM_RD, S_RM_CHK, S_SH_RD, S_SH_WR, S_FR_PUSH,
      S_DONE
   } state_type;

   // One frame table entry: reserved, continuation and used flags plus order.
   typedef struct packed {
      logic             resv;
      logic             cont;
      logic             used;
      logic [ORD_W-1:0] order;
   } ft_entry_type;

   typedef struct packed {
      state_type op;
      logic      accept;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic rsv_stop;
      logic scan_end;
      logic run_zero;
      logic rd_resv;
      logic dec_last;
      logic mk_done;
      logic s_end;
      logic cnt_nz;
      logic split_more;
      logic split_fit;
      logic free_bad;
      logic not_used;
      logic merge_stop;
      logic bud_bad;
      logic i_end;
      logic match;
      logic sh_end;
   } flags_type;

   // Number of significant bits of an 11-bit value.
   function automatic logic [ORD_W-1:0] bit_len(input logic [CNT_W-1:0] v);
      logic [ORD_W-1:0] r;
      r = '0;
      for (int b = 0; b < CNT_W; b++) begin
         if (v[b]) r = ORD_W'(b + 1);
      end
      return r;
   endfunction

   // Each order owns a region of the stack memory; order k starts here.
   function automatic logic [ST_AW-1:0] stack_base(input logic [ORD_W-1:0] k);
      logic [ST_AW:0] full;
      full = (ST_AW+1)'(ST_DEPTH);
      return ST_AW'(full - (full >> k));
   endfunction

endpackage

/* hdl/bpa_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/bpa_ctrl.sv */
// Sequencer of the buddy page allocator: walks each action through its steps.
`timescale 1ns / 1ps

module bpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_action,
   input  bpa_pkg::flags_type  flags,
   output bpa_pkg::cmd_type    cmd,
   output logic                busy
);

   bpa_pkg::state_type state_ff, state_in;
   bpa_pkg::state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::S_CLEAR;
         ret_ff   <= bpa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      busy       = (state_ff != bpa_pkg::S_IDLE);
      cmd.op     = state_ff;
      cmd.accept = (state_ff == bpa_pkg::S_IDLE) && start;
      unique case (state_ff)
         bpa_pkg::S_CLEAR: if (flags.clr_last) state_in = bpa_pkg::S_IDLE;
         bpa_pkg::S_IDLE: begin
            if (start) begin
               unique case (bpa_pkg::action_type'(req_action))
                  bpa_pkg::ACT_RESERVE: state_in = bpa_pkg::S_RSV_RD;
                  bpa_pkg::ACT_BUILD:   state_in = bpa_pkg::S_BLD_RD;
                  bpa_pkg::ACT_ALLOC:   state_in = bpa_pkg::S_AL_SRCH;
                  default:              state_in = bpa_pkg::S_FR_RD;
               endcase
            end
         end
         bpa_pkg::S_RSV_RD:
            state_in = flags.rsv_stop ? bpa_pkg::S_DONE : bpa_pkg::S_RSV_WR;
         bpa_pkg::S_RSV_WR: state_in = bpa_pkg::S_RSV_RD;
         bpa_pkg::S_BLD_RD: begin
            if (flags.scan_end)
               state_in = flags.run_zero ? bpa_pkg::S_DONE : bpa_pkg::S_BLD_DEC;
            else
               state_in = bpa_pkg::S_BLD_CHK;
         end
         bpa_pkg::S_BLD_CHK:
            state_in = (flags.rd_resv && !flags.run_zero) ? bpa_pkg::S_BLD_DEC
                                                          : bpa_pkg::S_BLD_RD;
         bpa_pkg::S_BLD_DEC: begin
            state_in = bpa_pkg::S_MK_RD;
            ret_in   = flags.dec_last ? bpa_pkg::S_BLD_RD : bpa_pkg::S_BLD_DEC;
         end
         bpa_pkg::S_MK_RD: state_in = flags.mk_done ? ret_ff : bpa_pkg::S_MK_WR;
         bpa_pkg::S_MK_WR: state_in = bpa_pkg::S_MK_RD;
         bpa_pkg::S_AL_SRCH: begin
            if (flags.s_end)       state_in = bpa_pkg::S_DONE;
            else if (flags.cnt_nz) state_in = bpa_pkg::S_AL_POP;
         end
         bpa_pkg::S_AL_POP: begin
            state_in = bpa_pkg::S_MK_RD;
            ret_in   = bpa_pkg::S_AL_SPLIT;
         end
         bpa_pkg::S_AL_SPLIT: begin
            if (!flags.split_more) begin
               state_in = bpa_pkg::S_MK_RD;
               ret_in   = bpa_pkg::S_DONE;
            end else if (flags.split_fit) begin
               state_in = bpa_pkg::S_MK_RD;
               ret_in   = bpa_pkg::S_AL_SPLIT;
            end
         end
         bpa_pkg::S_FR_RD:
            state_in = flags.free_bad ? bpa_pkg::S_DONE : bpa_pkg::S_FR_CHK;
         bpa_pkg::S_FR_CHK:
            state_in = flags.not_used ? bpa_pkg::S_DONE : bpa_pkg::S_FR_MERGE;
         bpa_pkg::S_FR_MERGE:
            state_in = flags.merge_stop ? bpa_pkg::S_FR_PUSH : bpa_pkg::S_FR_BUD;
         bpa_pkg::S_FR_BUD:
            state_in = flags.bud_bad ? bpa_pkg::S_FR_PUSH : bpa_pkg::S_RM_RD;
         bpa_pkg::S_RM_RD:
            state_in = flags.i_end ? bpa_pkg::S_FR_MERGE : bpa_pkg::S_RM_CHK;
         bpa_pkg::S_RM_CHK:
            state_in = flags.match ? bpa_pkg::S_SH_RD : bpa_pkg::S_RM_RD;
         bpa_pkg::S_SH_RD:
            state_in = flags.sh_end ? bpa_pkg::S_FR_MERGE : bpa_pkg::S_SH_WR;
         bpa_pkg::S_SH_WR: state_in = bpa_pkg::S_SH_RD;
         bpa_pkg::S_FR_PUSH: begin
            state_in = bpa_pkg::S_MK_RD;
            ret_in   = bpa_pkg::S_DONE;
         end
         bpa_pkg::S_DONE: state_in = bpa_pkg::S_IDLE;
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

endmodule

/* hdl/bpa_datapath.sv */
// Datapath of the buddy page allocator: frame table, free stacks and counters.
`timescale 1ns / 1ps

module bpa_datapath (
   input  logic               clock,
   input  logic               reset,
   input  bpa_pkg::cmd_type   cmd,
   input  logic [1:0]         req_action,
   input  logic [9:0]         req_frame,
   input  logic [9:0]         req_end_frame,
   input  logic [3:0]         req_order,
   input  logic               csr_valid,
   input  logic [10:0]        csr_total_frames,
   output bpa_pkg::flags_type flags,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [9:0]         rsp_frame_out,
   output logic [3:0]         rsp_order_out
);

   localparam int FW = bpa_pkg::FRM_W;
   localparam int OW = bpa_pkg::ORD_W;
   localparam int CW = bpa_pkg::CNT_W;

   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [FW-1:0] frame_ff, frame_in, end_ff, end_in;
   logic [OW-1:0] req_ff, req_in;
   logic [CW-1:0] n_ff, n_in;
   logic [OW-1:0] lvl_ff, lvl_in;
   logic [CW-1:0] off_ff, off_in, run_ff, run_in;
   logic [OW-1:0] s_ff, s_in;
   logic [FW-1:0] start_ff, start_in, cur_ff, cur_in, bud_ff, bud_in;
   logic [OW-1:0] ord_ff, ord_in;
   logic [OW:0]   k_ff, k_in;
   logic          first_ff, first_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] m_addr_ff, m_addr_in, m_i_ff, m_i_in;
   logic [OW-1:0] m_ord_ff, m_ord_in;
   bpa_pkg::mark_type   m_mode_ff, m_mode_in;
   bpa_pkg::status_type status_ff, status_in;
   logic [FW-1:0] fo_ff, fo_in;
   logic [OW-1:0] oo_ff, oo_in;
   logic [CW-1:0] cnt_ff [bpa_pkg::MAX_ORDERS];
   logic [CW-1:0] cnt_in [bpa_pkg::MAX_ORDERS];

   // Frame table and stack memory ports.
   logic          ft_we, ft_re;
   logic [FW-1:0] ft_waddr, ft_raddr;
   bpa_pkg::ft_entry_type ft_wdata, ft_rd;
   logic [$bits(bpa_pkg::ft_entry_type)-1:0] ft_rdata;
   logic          st_we, st_re;
   logic [bpa_pkg::ST_AW-1:0] st_addr;
   logic [FW-1:0] st_wdata, st_rd;

   // Shared selection and arithmetic.
   logic [OW-1:0] cidx, bord, kd;
   logic [CW-1:0] cnt_sel, lim, st_off, scan_p, bsz, half_sp, mk_size;
   logic [CW-1:0] m_half, m_mask, bud_c, cur_w;
   logic          first_c, cidx_ok;
   logic [CW-1:0] n_calc;
   bpa_pkg::ft_entry_type mk_val;

   assign ft_rd = bpa_pkg::ft_entry_type'(ft_rdata);

   bpa_ram #(.WIDTH($bits(bpa_pkg::ft_entry_type)), .DEPTH(bpa_pkg::FRAMES)) u_ft (
      .clock (clock),
      .we    (ft_we),
      .waddr (ft_waddr),
      .wdata (ft_wdata),
      .re    (ft_re),
      .raddr (ft_raddr),
      .rdata (ft_rdata)
   );

   bpa_ram #(.WIDTH(FW), .DEPTH(bpa_pkg::ST_DEPTH)) u_stk (
      .clock (clock),
      .we    (st_we),
      .waddr (st_addr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_addr),
      .rdata (st_rd)
   );

   always_comb begin
      n_calc = (csr_total_frames > CW'(bpa_pkg::FRAMES)) ? CW'(bpa_pkg::FRAMES)
                                                         : csr_total_frames;
      n_calc = (total_ff > CW'(bpa_pkg::FRAMES)) ? CW'(bpa_pkg::FRAMES) : total_ff;
      bord   = bpa_pkg::bit_len(run_ff) - OW'(1);
      bsz    = CW'(1) << bord;
      unique case (cmd.op)
         bpa_pkg::S_AL_SRCH:  cidx = s_ff;
         bpa_pkg::S_AL_SPLIT: cidx = s_ff - OW'(1);
         bpa_pkg::S_BLD_DEC:  cidx = bord;
         default:             cidx = ord_ff;
      endcase
      cidx_ok = (cidx < OW'(bpa_pkg::MAX_ORDERS));
      cnt_sel = cidx_ok ? cnt_ff[cidx] : '0;
      lim     = n_ff >> cidx;
      half_sp = {1'b0, start_ff} + (CW'(1) << cidx);
      scan_p  = off_ff + run_ff;
      mk_size = CW'(1) << m_ord_ff;
      kd      = k_ff[OW-1:0] - OW'(1);
      m_half  = CW'(1) << kd;
      m_mask  = (m_half << 1) - CW'(1);
      cur_w   = {1'b0, cur_ff};
      first_c = ((cur_w & m_mask) == '0);
      bud_c   = first_c ? (cur_w + m_half) : (cur_w - m_half);
      unique case (cmd.op)
         bpa_pkg::S_AL_SRCH: st_off = cnt_sel - CW'(1);
         bpa_pkg::S_RM_RD:   st_off = i_ff;
         bpa_pkg::S_SH_RD:   st_off = i_ff + CW'(1);
         bpa_pkg::S_SH_WR:   st_off = i_ff;
         default:            st_off = cnt_sel;
      endcase
      st_addr = bpa_pkg::stack_base(cidx) + st_off;

      // Frame table update for one frame of a block being marked.
      mk_val       = ft_rd;
      mk_val.order = m_ord_ff;
      if (m_mode_ff == bpa_pkg::MK_USED) begin
         mk_val.used = 1'b1;
         mk_val.cont = (m_i_ff != '0);
      end else begin
         mk_val.used = 1'b0;
         if (m_i_ff != '0) mk_val.cont = 1'b1;
         else if (m_mode_ff == bpa_pkg::MK_FREE) mk_val.cont = 1'b0;
      end

      flags.clr_last   = (idx_ff == CW'(bpa_pkg::FRAMES - 1));
      flags.rsv_stop   = (idx_ff > {1'b0, end_ff});
      flags.scan_end   = (scan_p >= n_ff);
      flags.run_zero   = (run_ff == '0);
      flags.rd_resv    = ft_rd.resv;
      flags.dec_last   = (run_ff == bsz);
      flags.mk_done    = (m_i_ff >= mk_size) || (m_addr_ff >= CW'(bpa_pkg::FRAMES));
      flags.s_end      = (s_ff >= lvl_ff);
      flags.cnt_nz     = (cnt_sel != '0);
      flags.split_more = (s_ff > req_ff);
      flags.split_fit  = (cnt_sel < lim);
      flags.free_bad   = ({1'b0, frame_ff} >= n_ff);
      flags.not_used   = !ft_rd.used;
      flags.merge_stop = (k_ff >= {1'b0, lvl_ff}) || (!first_c && (cur_w < m_half))
                         || (bud_c >= n_ff);
      flags.bud_bad    = ft_rd.resv || ft_rd.used || (ft_rd.order != kd);
      flags.i_end      = (i_ff >= cnt_sel);
      flags.match      = (st_rd == bud_ff);
      flags.sh_end     = ((i_ff + CW'(1)) >= cnt_sel);
   end

   always_comb begin
      total_in  = total_ff;  idx_in    = idx_ff;    frame_in  = frame_ff;
      end_in    = end_ff;    req_in    = req_ff;    n_in      = n_ff;
      lvl_in    = lvl_ff;    off_in    = off_ff;    run_in    = run_ff;
      s_in      = s_ff;      start_in  = start_ff;  cur_in    = cur_ff;
      bud_in    = bud_ff;    ord_in    = ord_ff;    k_in      = k_ff;
      first_in  = first_ff;  i_in      = i_ff;      m_addr_in = m_addr_ff;
      m_i_in    = m_i_ff;    m_ord_in  = m_ord_ff;  m_mode_in = m_mode_ff;
      status_in = status_ff; fo_in     = fo_ff;     oo_in     = oo_ff;
      cnt_in    = cnt_ff;
      ft_we = 1'b0; ft_re = 1'b0; ft_waddr = idx_ff[FW-1:0]; ft_raddr = idx_ff[FW-1:0];
      ft_wdata = '0;
      st_we = 1'b0; st_re = 1'b0; st_wdata = cur_ff;

      if (csr_valid && !(cmd.op != bpa_pkg::S_IDLE && 1'b0)) total_in = csr_total_frames;
      if (!csr_valid) total_in = total_ff;

      unique case (cmd.op)
         bpa_pkg::S_CLEAR: begin
            ft_we  = 1'b1;
            idx_in = idx_ff + CW'(1);
         end
         bpa_pkg::S_IDLE: begin
            if (cmd.accept) begin
               frame_in  = req_frame;
               end_in    = req_end_frame;
               req_in    = req_order;
               n_in      = n_calc;
               lvl_in    = bpa_pkg::bit_len(n_calc);
               idx_in    = {1'b0, req_frame};
               s_in      = req_order;
               off_in    = '0;
               run_in    = '0;
               status_in = bpa_pkg::ST_OK;
               fo_in     = '0;
               oo_in     = '0;
               if (bpa_pkg::action_type'(req_action) == bpa_pkg::ACT_BUILD) begin
                  for (int j = 0; j < bpa_pkg::MAX_ORDERS; j++) cnt_in[j] = '0;
               end
            end
         end
         bpa_pkg::S_RSV_RD: ft_re = !flags.rsv_stop;
         bpa_pkg::S_RSV_WR: begin
            ft_we         = 1'b1;
            ft_wdata      = ft_rd;
            ft_wdata.resv = 1'b1;
            idx_in        = idx_ff + CW'(1);
         end
         bpa_pkg::S_BLD_RD: begin
            ft_re    = !flags.scan_end;
            ft_raddr = scan_p[FW-1:0];
         end
         bpa_pkg::S_BLD_CHK: begin
            if (!ft_rd.resv)   run_in = run_ff + CW'(1);
            else if (flags.run_zero) off_in = off_ff + CW'(1);
         end
         bpa_pkg::S_BLD_DEC: begin
            if (cnt_sel <= lim) begin
               st_we        = 1'b1;
               st_wdata     = off_ff[FW-1:0];
               cnt_in[cidx] = cnt_sel + CW'(1);
            end
            m_addr_in = off_ff;
            m_ord_in  = bord;
            m_mode_in = bpa_pkg::MK_BUILD;
            m_i_in    = '0;
            off_in    = off_ff + bsz;
            run_in    = run_ff - bsz;
         end
         bpa_pkg::S_MK_RD: begin
            ft_re    = !flags.mk_done;
            ft_raddr = m_addr_ff[FW-1:0];
         end
         bpa_pkg::S_MK_WR: begin
            ft_we     = 1'b1;
            ft_waddr  = m_addr_ff[FW-1:0];
            ft_wdata  = mk_val;
            m_addr_in = m_addr_ff + CW'(1);
            m_i_in    = m_i_ff + CW'(1);
         end
         bpa_pkg::S_AL_SRCH: begin
            if (flags.s_end) begin
               status_in = bpa_pkg::ST_NO_MEM;
            end else if (flags.cnt_nz) begin
               st_re        = 1'b1;
               cnt_in[cidx] = cnt_sel - CW'(1);
            end else begin
               s_in = s_ff + OW'(1);
            end
         end
         bpa_pkg::S_AL_POP: begin
            start_in  = st_rd;
            m_addr_in = {1'b0, st_rd};
            m_ord_in  = s_ff;
            m_mode_in = bpa_pkg::MK_USED;
            m_i_in    = '0;
         end
         bpa_pkg::S_AL_SPLIT: begin
            m_i_in = '0;
            if (flags.split_more) begin
               s_in = cidx;
               if (flags.split_fit) begin
                  st_we        = 1'b1;
                  st_wdata     = half_sp[FW-1:0];
                  cnt_in[cidx] = cnt_sel + CW'(1);
                  m_addr_in    = half_sp;
                  m_ord_in     = cidx;
                  m_mode_in    = bpa_pkg::MK_FREE;
               end else begin
                  status_in = bpa_pkg::ST_LIST_FULL;
               end
            end else begin
               m_addr_in = {1'b0, start_ff};
               m_ord_in  = req_ff;
               m_mode_in = bpa_pkg::MK_USED;
               fo_in     = start_ff;
               oo_in     = req_ff;
            end
         end
         bpa_pkg::S_FR_RD: begin
            if (flags.free_bad) begin
               status_in = bpa_pkg::ST_DBL_FREE;
               fo_in     = frame_ff;
            end else begin
               ft_re    = 1'b1;
               ft_raddr = frame_ff;
            end
         end
         bpa_pkg::S_FR_CHK: begin
            if (flags.not_used) begin
               status_in = bpa_pkg::ST_DBL_FREE;
               fo_in     = frame_ff;
            end else begin
               ord_in = ft_rd.order;
               cur_in = frame_ff;
               k_in   = {1'b0, ft_rd.order} + (OW+1)'(1);
            end
         end
         bpa_pkg::S_FR_MERGE: begin
            bud_in   = bud_c[FW-1:0];
            first_in = first_c;
            ft_re    = !flags.merge_stop;
            ft_raddr = bud_c[FW-1:0];
         end
         bpa_pkg::S_FR_BUD: i_in = '0;
         bpa_pkg::S_RM_RD: begin
            if (flags.i_end) begin
               if (!first_ff) cur_in = bud_ff;
               ord_in = ord_ff + OW'(1);
               k_in   = k_ff + (OW+1)'(1);
            end else begin
               st_re = 1'b1;
            end
         end
         bpa_pkg::S_RM_CHK: if (!flags.match) i_in = i_ff + CW'(1);
         bpa_pkg::S_SH_RD: begin
            if (flags.sh_end) begin
               if (cidx_ok) cnt_in[cidx] = cnt_sel - CW'(1);
               if (!first_ff) cur_in = bud_ff;
               ord_in = ord_ff + OW'(1);
               k_in   = k_ff + (OW+1)'(1);
            end else begin
               st_re = 1'b1;
            end
         end
         bpa_pkg::S_SH_WR: begin
            st_we    = 1'b1;
            st_wdata = st_rd;
            i_in     = i_ff + CW'(1);
         end
         bpa_pkg::S_FR_PUSH: begin
            if (cidx_ok && (cnt_sel <= lim)) begin
               st_we        = 1'b1;
               st_wdata     = cur_ff;
               cnt_in[cidx] = cnt_sel + CW'(1);
            end else begin
               status_in = bpa_pkg::ST_LIST_FULL;
            end
            m_addr_in = {1'b0, cur_ff};
            m_ord_in  = ord_ff;
            m_mode_in = bpa_pkg::MK_FREE;
            m_i_in    = '0;
            fo_in     = cur_ff;
            oo_in     = ord_ff;
         end
         bpa_pkg::S_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CW'(bpa_pkg::FRAMES);
         idx_ff   <= '0;
         for (int j = 0; j < bpa_pkg::MAX_ORDERS; j++) cnt_ff[j] <= '0;
      end else begin
         total_ff <= total_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff  <= frame_in;  end_ff    <= end_in;    req_ff    <= req_in;
      n_ff      <= n_in;      lvl_ff    <= lvl_in;    off_ff    <= off_in;
      run_ff    <= run_in;    s_ff      <= s_in;      start_ff  <= start_in;
      cur_ff    <= cur_in;    bud_ff    <= bud_in;    ord_ff    <= ord_in;
      k_ff      <= k_in;      first_ff  <= first_in;  i_ff      <= i_in;
      m_addr_ff <= m_addr_in; m_i_ff    <= m_i_in;    m_ord_ff  <= m_ord_in;
      m_mode_ff <= m_mode_in; status_ff <= status_in; fo_ff     <= fo_in;
      oo_ff     <= oo_in;
   end

   assign rsp_strobe    = (cmd.op == bpa_pkg::S_DONE);
   assign rsp_status    = status_ff;
   assign rsp_frame_out = fo_ff;
   assign rsp_order_out = oo_ff;

endmodule

/* hdl/buddy_page_allocator.sv */
// Top level of the buddy page allocator: sequencer plus datapath.
`timescale 1ns / 1ps

// Channel   Ports                                         Beat taken when
// request   start, busy, req_action/frame/end_frame/order start high, busy low
// response  rsp_strobe, rsp_status/frame_out/order_out    rsp_strobe high
// config    csr_valid, csr_ready, csr_total_frames        csr_valid, csr_ready
//
// One request is handled at a time; busy stays high until its single response
// beat has been shown for one cycle. Cost is set by the walks over the frame
// table and stack memory: each frame marked or reserved passes a read and a
// write state, each stack entry searched or shifted a read and then a check
// or write state. After reset all 1024 frame table entries are cleared, one
// entry a cycle, with busy high. The receiver cannot stall the response.

module buddy_page_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [9:0]  req_frame,
   input  logic [9:0]  req_end_frame,
   input  logic [3:0]  req_order,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_frame_out,
   output logic [3:0]  rsp_order_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_total_frames
);

   bpa_pkg::cmd_type   cmd;
   bpa_pkg::flags_type flags;

   // The frame count is latched at the start of each request, so the register
   // can always take a write.
   assign csr_ready = 1'b1;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .flags      (flags),
      .cmd        (cmd),
      .busy       (busy)
   );

   bpa_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_frame        (req_frame),
      .req_end_frame    (req_end_frame),
      .req_order        (req_order),
      .csr_valid        (csr_valid),
      .csr_total_frames (csr_total_frames),
      .flags            (flags),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_frame_out    (rsp_frame_out),
      .rsp_order_out    (rsp_order_out)
   );

endmodule
